// ===== rtl/dspa_pkg.sv =====
// Shared widths, constants, register indexes and helpers for the dust sensor pulse averager.
package dspa_pkg;

  // Field widths.
  localparam int ADC_W   = 13;
  localparam int GAIN_W  = 16;
  localparam int OFF_W   = 13;
  localparam int WAIT_W  = 16;
  localparam int WIN_W   = 16;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int PM_W    = 10;
  localparam int FRAC_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Timing and range constants.
  localparam int TICKS_PER_MS = 1000;
  localparam int MAX_MV       = 4000;
  localparam int WT_W         = 26;
  localparam logic [WT_W-1:0] WT_MAX = {WT_W{1'b1}};

  // Output scaling: pm = 170 * sum / (1000 * count).
  localparam int PM_SCALE  = 170;
  localparam int DEN_SCALE = 1000;
  localparam int KN_W = $clog2(PM_SCALE + 1);
  localparam int KD_W = $clog2(DEN_SCALE + 1);
  localparam int SCALE_STEPS = (KD_W > KN_W) ? KD_W : KN_W;
  localparam int NUM_W = SUM_W + KN_W;
  localparam int DEN_W = CNT_W + KD_W;

  // Multiplier product and scaled value.
  localparam int PROD_W = ADC_W + GAIN_W;
  localparam int SCL_W  = PROD_W - FRAC_W;
  localparam int V_W    = SCL_W + 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BEFORE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_AFTER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_OFF    = 3'd5;

  // Pulse phase codes; the unused code behaves like the LED-off phase.
  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_AFTER  = 2'd1;
  localparam logic [1:0] PH_OFF    = 2'd2;

  // Window length in ticks, saturated to the window timer range.
  function automatic logic [WT_W-1:0] window_limit(input logic [WIN_W-1:0] ms);
    logic [47:0] prod;
    prod = 48'(ms) * 48'(TICKS_PER_MS);
    if (prod > 48'(WT_MAX)) begin
      return WT_MAX;
    end
    return prod[WT_W-1:0];
  endfunction

endpackage

// ===== rtl/dspa_mul.sv =====
// Bit-serial shift-add multiplier that scales a converter reading by the Q4.12 gain.
module dspa_mul import dspa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADC_W-1:0]  adc_i,
  input  logic [GAIN_W-1:0] gain_i,
  output logic              done_o,
  output logic [SCL_W-1:0]  scaled_o
);

  localparam int STEP_W = $clog2(GAIN_W);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_RUN  = 3'b010,
    M_FIN  = 3'b100
  } mul_state_e;

  mul_state_e          st_q, st_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [ADC_W-1:0]    a_q, a_d;
  logic [PROD_W-1:0]   p_q, p_d;
  logic [ADC_W:0]      part_sum;

  // The multiplier bits sit in the low half of the product register and
  // leave it one per cycle as partial sums shift in from the top.
  assign part_sum = {1'b0, p_q[PROD_W-1:GAIN_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    a_d    = a_q;
    p_d    = p_q;
    unique case (st_q)
      M_IDLE: begin
        if (start_i) begin
          a_d    = adc_i;
          p_d    = {{ADC_W{1'b0}}, gain_i};
          step_d = STEP_W'(GAIN_W - 1);
          st_d   = M_RUN;
        end
      end
      M_RUN: begin
        p_d    = {part_sum, p_q[GAIN_W-1:1]};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          st_d = M_FIN;
        end
      end
      M_FIN: begin
        st_d = M_IDLE;
      end
      default: begin
        st_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= M_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    a_q    <= a_d;
    p_q    <= p_d;
  end

  assign done_o   = (st_q == M_FIN);
  assign scaled_o = p_q[PROD_W-1:FRAC_W];

endmodule

// ===== rtl/dspa_div.sv =====
// Serial constant scaling of sum and count followed by a restoring bit-serial divider.
module dspa_div import dspa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [CNT_W-1:0] count_i,
  output logic             done_o,
  output logic [PM_W-1:0]  pm_o
);

  localparam int STEP_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_SCALE = 4'b0010,
    D_DIV   = 4'b0100,
    D_FIN   = 4'b1000
  } div_state_e;

  div_state_e              st_q, st_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [SCALE_STEPS-1:0]  kn_q, kn_d, kd_q, kd_d;
  logic [NUM_W-1:0]        xn_q, xn_d, n_q, n_d;
  logic [DEN_W-1:0]        xd_q, xd_d, d_q, d_d;
  logic [DEN_W-1:0]        r_q, r_d;
  logic [DEN_W:0]          trial, diff;

  // One quotient bit per cycle: the next numerator bit joins the remainder.
  assign trial = {r_q, n_q[NUM_W-1]};
  assign diff  = trial - {1'b0, d_q};

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    kn_d   = kn_q;
    kd_d   = kd_q;
    xn_d   = xn_q;
    n_d    = n_q;
    xd_d   = xd_q;
    d_d    = d_q;
    r_d    = r_q;
    unique case (st_q)
      D_IDLE: begin
        if (start_i) begin
          kn_d   = SCALE_STEPS'(PM_SCALE);
          kd_d   = SCALE_STEPS'(DEN_SCALE);
          xn_d   = NUM_W'(sum_i);
          xd_d   = DEN_W'(count_i);
          n_d    = '0;
          d_d    = '0;
          step_d = STEP_W'(SCALE_STEPS - 1);
          st_d   = D_SCALE;
        end
      end
      D_SCALE: begin
        // Constant multipliers are consumed one bit per cycle.
        if (kn_q[0]) begin
          n_d = n_q + xn_q;
        end
        if (kd_q[0]) begin
          d_d = d_q + xd_q;
        end
        xn_d   = {xn_q[NUM_W-2:0], 1'b0};
        xd_d   = {xd_q[DEN_W-2:0], 1'b0};
        kn_d   = kn_q >> 1;
        kd_d   = kd_q >> 1;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          r_d    = '0;
          step_d = STEP_W'(NUM_W - 1);
          st_d   = D_DIV;
        end
      end
      D_DIV: begin
        if (!diff[DEN_W]) begin
          r_d = diff[DEN_W-1:0];
        end else begin
          r_d = trial[DEN_W-1:0];
        end
        n_d    = {n_q[NUM_W-2:0], ~diff[DEN_W]};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          st_d = D_FIN;
        end
      end
      D_FIN: begin
        st_d = D_IDLE;
      end
      default: begin
        st_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= D_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    kn_q   <= kn_d;
    kd_q   <= kd_d;
    xn_q   <= xn_d;
    n_q    <= n_d;
    xd_q   <= xd_d;
    d_q    <= d_d;
    r_q    <= r_d;
  end

  assign done_o = (st_q == D_FIN);
  // Quotients beyond the output range saturate.
  assign pm_o   = (|n_q[NUM_W-1:PM_W]) ? {PM_W{1'b1}} : n_q[PM_W-1:0];

endmodule

// ===== rtl/dust_sensor_pulse_averager.sv =====
// Top level of the dust sensor pulse averager: control, configuration and output register.
//
// Usage: each input transaction is either a one-microsecond tick (cmd_i = 0)
// or a start command (cmd_i = 1) that opens a new measurement window and
// clears the running sum and count. Every input transaction yields exactly
// one output transaction carrying the LED drive level, the window state, the
// sample count and, at the close of a window with kept samples, the
// particulate value with pm_valid_o set.
// Flow: a plain tick or a start passes from the accepting edge through the
// output state into the output register once that register is free. A tick
// that captures a valid reading first runs the 16-step bit-serial gain
// multiplier and the accumulate state. A tick that closes a window with
// samples first runs serial constant scaling and the bit-serial restoring divider.
// Throughput: one item at a time; in_stall_o is high while an item is at
// work. The output register lets the next item enter while a result waits.
// A stalled output holds its transaction; the core then waits before it
// writes the next result. Configuration writes are always ready and take
// effect at once; they are meant to be issued while the block is idle.
// Reset: the window is closed, counters are clear, and the registers take
// their default values (5000 ms window, unity gain, 280/40/9680 us waits).
module dust_sensor_pulse_averager import dspa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [ADC_W-1:0]      adc_mv_i,
  input  logic                  adc_valid_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  led_on_o,
  output logic                  pm_valid_o,
  output logic [PM_W-1:0]       pm_value_o,
  output logic                  sampling_o,
  output logic [CNT_W-1:0]      sample_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } top_state_e;

  // Configuration registers. The window limit is kept in ticks.
  logic [WT_W-1:0]    lim_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [OFF_W-1:0]   offset_q;
  logic [WAIT_W-1:0]  wait_before_q, wait_after_q, wait_off_q;
  logic               cfg_we;

  // Measurement state.
  top_state_e         st_q, st_d;
  logic               open_q, open_d;
  logic [1:0]         phase_q, phase_d;
  logic [WAIT_W-1:0]  ptim_q, ptim_d;
  logic [WT_W-1:0]    wtim_q, wtim_d, wt_inc;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               pmv_q, pmv_d;
  logic [PM_W-1:0]    pmval_q, pmval_d;
  logic [V_W-1:0]     v_q, v_d;
  logic [WAIT_W-1:0]  wait_sel;

  // Serial units.
  logic               mul_start, mul_done;
  logic [SCL_W-1:0]   mul_scaled;
  logic               div_start, div_done;
  logic [PM_W-1:0]    div_pm;

  // Output register.
  logic               out_valid_q;
  logic               out_load;
  logic               led_q, pmv_out_q, sampling_q;
  logic [PM_W-1:0]    pmval_out_q;
  logic [CNT_W-1:0]   cnt_out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q         <= window_limit(WIN_W'(5000));
      gain_q        <= GAIN_W'(4096);
      offset_q      <= '0;
      wait_before_q <= WAIT_W'(280);
      wait_after_q  <= WAIT_W'(40);
      wait_off_q    <= WAIT_W'(9680);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        CFG_WINDOW_MS:   lim_q         <= window_limit(cfg_data_i[WIN_W-1:0]);
        CFG_GAIN:        gain_q        <= cfg_data_i[GAIN_W-1:0];
        CFG_OFFSET:      offset_q      <= cfg_data_i[OFF_W-1:0];
        CFG_WAIT_BEFORE: wait_before_q <= cfg_data_i[WAIT_W-1:0];
        CFG_WAIT_AFTER:  wait_after_q  <= cfg_data_i[WAIT_W-1:0];
        CFG_WAIT_OFF:    wait_off_q    <= cfg_data_i[WAIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The phase timer is compared against the wait of the current phase.
  always_comb begin
    case (phase_q)
      PH_BEFORE: wait_sel = wait_before_q;
      PH_AFTER:  wait_sel = wait_after_q;
      default:   wait_sel = wait_off_q;
    endcase
  end

  assign wt_inc     = (wtim_q == WT_MAX) ? wtim_q : wtim_q + 1'b1;
  assign in_stall_o = (st_q != ST_IDLE);

  always_comb begin
    st_d      = st_q;
    open_d    = open_q;
    phase_d   = phase_q;
    ptim_d    = ptim_q;
    wtim_d    = wtim_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    pmv_d     = pmv_q;
    pmval_d   = pmval_q;
    v_d       = v_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pmv_d   = 1'b0;
          pmval_d = '0;
          st_d    = ST_OUT;
          if (cmd_i) begin
            // A start restarts the window even when one is already open.
            open_d  = 1'b1;
            phase_d = PH_BEFORE;
            ptim_d  = '0;
            wtim_d  = '0;
            cnt_d   = '0;
            sum_d   = '0;
          end else if (open_q) begin
            wtim_d = wt_inc;
            if (ptim_q < wait_sel) begin
              ptim_d = ptim_q + 1'b1;
            end else begin
              ptim_d = '0;
              case (phase_q)
                PH_BEFORE: begin
                  // The capture happens as the before-sample phase ends.
                  phase_d = PH_AFTER;
                  if (adc_valid_i && (cnt_q != {CNT_W{1'b1}})) begin
                    mul_start = 1'b1;
                    st_d      = ST_MUL;
                  end
                end
                PH_AFTER: begin
                  phase_d = PH_OFF;
                end
                default: begin
                  // End of a pulse cycle: the window may close here.
                  phase_d = PH_BEFORE;
                  if (wt_inc >= lim_q) begin
                    open_d = 1'b0;
                    if (cnt_q != '0) begin
                      div_start = 1'b1;
                      st_d      = ST_DIV;
                    end
                  end
                end
              endcase
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          v_d  = {2'b00, mul_scaled} - {{(V_W - OFF_W){offset_q[OFF_W-1]}}, offset_q};
          st_d = ST_ACC;
        end
      end
      ST_ACC: begin
        // Keep the sample only if it lies within zero to the full-scale limit.
        if (!v_q[V_W-1] && (v_q[V_W-2:0] <= (V_W - 1)'(MAX_MV))) begin
          cnt_d = cnt_q + 1'b1;
          sum_d = sum_q + SUM_W'(v_q[V_W-2:0]);
        end
        st_d = ST_OUT;
      end
      ST_DIV: begin
        if (div_done) begin
          pmv_d   = 1'b1;
          pmval_d = div_pm;
          st_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      open_q  <= 1'b0;
      phase_q <= PH_BEFORE;
      ptim_q  <= '0;
      wtim_q  <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      pmv_q   <= 1'b0;
      pmval_q <= '0;
    end else begin
      st_q    <= st_d;
      open_q  <= open_d;
      phase_q <= phase_d;
      ptim_q  <= ptim_d;
      wtim_q  <= wtim_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      pmv_q   <= pmv_d;
      pmval_q <= pmval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  dspa_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .adc_i    (adc_mv_i),
    .gain_i   (gain_q),
    .done_o   (mul_done),
    .scaled_o (mul_scaled)
  );

  dspa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .count_i (cnt_q),
    .done_o  (div_done),
    .pm_o    (div_pm)
  );

  // The result leaves the core only when the output register is free or
  // being emptied in the same cycle.
  assign out_load = (st_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      led_q       <= open_q && (phase_q == PH_BEFORE || phase_q == PH_AFTER);
      pmv_out_q   <= pmv_q;
      pmval_out_q <= pmval_q;
      sampling_q  <= open_q;
      cnt_out_q   <= cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_on_o       = led_q;
  assign pm_valid_o     = pmv_out_q;
  assign pm_value_o     = pmval_out_q;
  assign sampling_o     = sampling_q;
  assign sample_count_o = cnt_out_q;

endmodule

// ===== rtl/dspa_chk.sv =====
// Port-level checker for the dust sensor pulse averager and its bind statement.
module dspa_chk import dspa_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             led_on_o,
  input logic             pm_valid_o,
  input logic [PM_W-1:0]  pm_value_o,
  input logic             sampling_o,
  input logic [CNT_W-1:0] sample_count_o
);

  // A stalled output transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // A particulate value is only reported as its window closes.
  a_pm_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pm_valid_o |-> !sampling_o)
    else $error("particulate value reported with the window still open");

  // A particulate value implies at least one kept sample.
  a_pm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pm_valid_o |-> sample_count_o != '0)
    else $error("particulate value reported without samples");

  // Without a new value the value field reads zero.
  a_pm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pm_valid_o |-> pm_value_o == '0)
    else $error("stale particulate value on the output");

  // The LED is dark whenever no window is open.
  a_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sampling_o |-> !led_on_o)
    else $error("LED driven outside a measurement window");

endmodule

bind dust_sensor_pulse_averager dspa_chk u_dspa_chk (.*);
